@@ design/gcd_pkg.sv @@
package gcd_pkg;

  // fixed-point format
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STAGES   = 32;
  localparam int QBITS           = 30;
  localparam int SQRT_STAGES     = 32;
  localparam int CW              = 34;   // cordic datapath width, signed

  // coordinate limits in input units
  localparam logic signed [25:0] LAT_LIMIT = 26'sd90 <<< ANGLE_FRAC_BITS;
  localparam logic signed [25:0] LON_LIMIT = 26'sd180 <<< ANGLE_FRAC_BITS;

  // pi/180 in Q60, split for two narrow multipliers
  localparam int PI_SPLIT = 28;
  localparam logic [54:0] PI180    = 55'd20122276272436452;
  localparam logic [26:0] PI180_HI = PI180[54:PI_SPLIT];
  localparam logic [27:0] PI180_LO = PI180[PI_SPLIT-1:0];
  localparam int SHIFT_ABS  = QBITS + ANGLE_FRAC_BITS;
  localparam int SHIFT_HALF = QBITS + 1 + ANGLE_FRAC_BITS;

  // pi in Q30 and inverse cordic gain in Q30
  localparam logic [32:0]          PI30 = 33'd3373259426;
  localparam logic signed [CW-1:0] KINV = 34'sd652032874;
  localparam logic signed [CW-1:0] QONE = 34'sd1 <<< QBITS;

  // output scaling
  localparam logic [13:0] DIAM_KM    = 14'd12742;
  localparam logic [14:0] DIST_LIMIT = 15'd20015;

  // pipeline stage numbering
  localparam int S_IN    = 0;
  localparam int S_MUL   = 1;
  localparam int S_SUM   = 2;
  localparam int S_FOLD  = 3;
  localparam int S_ROT   = 4;
  localparam int S_SQ    = S_ROT + CORDIC_STAGES;
  localparam int S_AB    = S_SQ + 1;
  localparam int S_CL    = S_SQ + 2;
  localparam int S_RT    = S_CL + 1;
  localparam int S_VEC   = S_RT + SQRT_STAGES;
  localparam int S_KM    = S_VEC + CORDIC_STAGES;
  localparam int S_OUT   = S_KM + 1;
  localparam int NSTAGE  = S_OUT + 1;

  // atan(2^-i) in Q30, rounded half up
  function automatic logic signed [CW-1:0] atan_tab(input int unsigned i);
    logic signed [CW-1:0] v;
    begin
      unique case (i)
        0:  v = 34'sd843314857;
        1:  v = 34'sd497837829;
        2:  v = 34'sd263043837;
        3:  v = 34'sd133525159;
        4:  v = 34'sd67021687;
        5:  v = 34'sd33543516;
        6:  v = 34'sd16775851;
        7:  v = 34'sd8388437;
        8:  v = 34'sd4194283;
        9:  v = 34'sd2097149;
        default: v = (i <= 30) ? (34'sd1 <<< (30 - i)) : 34'sd1;
      endcase
      return v;
    end
  endfunction

endpackage

@@ design/great_circle_distance.sv @@
// channel  | handshake               | payload
// ---------+-------------------------+-------------------------------------------
// in       | in_valid / in_ready     | in_start_latitude, in_start_longitude,
//          |                         | in_end_latitude, in_end_longitude
// out      | out_valid / out_ready   | out_dist_km
//
// fully pipelined: one request per cycle unless out_ready back-pressure stalls a full pipeline
// the depth is set mostly by two 32-stage cordic chains and a 32-stage square root
// synchronous active-low reset clears only the stage valid bits
// each stage holds while the stage after it is full and stalled, so bubbles
// are squeezed out and a stall drops or repeats nothing
module great_circle_distance
  import gcd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_start_latitude,
  input  logic signed [24:0] in_start_longitude,
  input  logic signed [23:0] in_end_latitude,
  input  logic signed [24:0] in_end_longitude,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [14:0]        out_dist_km
);

  // stage valid bits and load enables
  logic [NSTAGE-1:0] v_r;
  logic [NSTAGE:0]   en;

  assign en[NSTAGE] = out_ready;
  genvar k;
  generate
    for (k = 0; k < NSTAGE; k++) begin : g_ctl
      assign en[k] = !v_r[k] || en[k+1];
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en[k]) begin
          if (k == 0) begin
            v_r[k] <= in_valid;
          end else begin
            v_r[k] <= v_r[(k == 0) ? 0 : k-1];
          end
        end
      end
    end
  endgenerate

  assign in_ready  = en[0];
  assign out_valid = v_r[NSTAGE-1];

  // clamp inputs and take angle magnitudes
  logic signed [25:0] lat1_c, lat2_c, lon1_c, lon2_c;
  logic signed [26:0] dlat, dlon;
  logic [24:0]        mag_nxt [4];
  logic [24:0]        mag_r   [4];

  function automatic logic signed [25:0] sat(input logic signed [25:0] v,
                                             input logic signed [25:0] lim);
    if (v > lim) return lim;
    else if (v < -lim) return -lim;
    else return v;
  endfunction

  function automatic logic [24:0] absv(input logic signed [26:0] v);
    logic signed [26:0] a;
    begin
      a = (v < 0) ? -v : v;
      return a[24:0];
    end
  endfunction

  always_comb begin
    lat1_c = sat(26'(in_start_latitude), LAT_LIMIT);
    lat2_c = sat(26'(in_end_latitude), LAT_LIMIT);
    lon1_c = sat(26'(in_start_longitude), LON_LIMIT);
    lon2_c = sat(26'(in_end_longitude), LON_LIMIT);
    dlat   = 27'(lat2_c) - 27'(lat1_c);
    dlon   = 27'(lon2_c) - 27'(lon1_c);
    mag_nxt[0] = absv(27'(lat1_c));
    mag_nxt[1] = absv(27'(lat2_c));
    mag_nxt[2] = absv(dlat);
    mag_nxt[3] = absv(dlon);
  end

  always_ff @(posedge clk) begin
    if (en[S_IN]) begin
      mag_r <= mag_nxt;
    end
  end

  // degree to radian: partial products against pi/180
  logic [51:0] pph_r [4];
  logic [52:0] ppl_r [4];
  logic [31:0] ang_r [4];
  logic [79:0] full  [4];

  always_ff @(posedge clk) begin
    if (en[S_MUL]) begin
      for (int j = 0; j < 4; j++) begin
        pph_r[j] <= 52'(mag_r[j]) * 52'(PI180_HI);
        ppl_r[j] <= 53'(mag_r[j]) * 53'(PI180_LO);
      end
    end
  end

  // sum partial products and scale to q30
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      full[j] = (80'(pph_r[j]) << PI_SPLIT) + 80'(ppl_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_SUM]) begin
      ang_r[0] <= 32'(full[0] >> SHIFT_ABS);
      ang_r[1] <= 32'(full[1] >> SHIFT_ABS);
      ang_r[2] <= 32'(full[2] >> SHIFT_HALF);
      ang_r[3] <= 32'(full[3] >> SHIFT_HALF);
    end
  end

  // fold half longitude difference beyond a right angle
  logic signed [CW-1:0] z0_r [4];
  logic [32:0]          lam2;
  logic [32:0]          lam_f;

  always_comb begin
    lam2  = {ang_r[3], 1'b0};
    lam_f = (lam2 > PI30) ? (PI30 - 33'(ang_r[3])) : 33'(ang_r[3]);
  end

  always_ff @(posedge clk) begin
    if (en[S_FOLD]) begin
      z0_r[0] <= CW'(ang_r[0]);
      z0_r[1] <= CW'(ang_r[1]);
      z0_r[2] <= CW'(ang_r[2]);
      z0_r[3] <= CW'(lam_f);
    end
  end

  // rotation cordic, four lanes, one stage per iteration
  logic signed [CW-1:0] rx_r [CORDIC_STAGES][4];
  logic signed [CW-1:0] ry_r [CORDIC_STAGES][4];
  logic signed [CW-1:0] rz_r [CORDIC_STAGES][4];

  genvar i;
  generate
    for (i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      logic signed [CW-1:0] xi [4];
      logic signed [CW-1:0] yi [4];
      logic signed [CW-1:0] zi [4];
      always_comb begin
        for (int j = 0; j < 4; j++) begin
          if (i == 0) begin
            xi[j] = KINV;
            yi[j] = '0;
            zi[j] = z0_r[j];
          end else begin
            xi[j] = rx_r[(i == 0) ? 0 : i-1][j];
            yi[j] = ry_r[(i == 0) ? 0 : i-1][j];
            zi[j] = rz_r[(i == 0) ? 0 : i-1][j];
          end
        end
      end
      always_ff @(posedge clk) begin
        if (en[S_ROT+i]) begin
          for (int j = 0; j < 4; j++) begin
            if (zi[j] >= 0) begin
              rx_r[i][j] <= xi[j] - (yi[j] >>> i);
              ry_r[i][j] <= yi[j] + (xi[j] >>> i);
              rz_r[i][j] <= zi[j] - atan_tab(i);
            end else begin
              rx_r[i][j] <= xi[j] + (yi[j] >>> i);
              ry_r[i][j] <= yi[j] - (xi[j] >>> i);
              rz_r[i][j] <= zi[j] + atan_tab(i);
            end
          end
        end
      end
    end
  endgenerate

  // squares and cosine product
  logic signed [CW-1:0]   sq1_r, sq2_r, cc_r;
  logic signed [2*CW-1:0] p_s1, p_s2, p_cc;

  always_comb begin
    p_s1 = (2*CW)'(ry_r[CORDIC_STAGES-1][2]) * (2*CW)'(ry_r[CORDIC_STAGES-1][2]);
    p_s2 = (2*CW)'(ry_r[CORDIC_STAGES-1][3]) * (2*CW)'(ry_r[CORDIC_STAGES-1][3]);
    p_cc = (2*CW)'(rx_r[CORDIC_STAGES-1][0]) * (2*CW)'(rx_r[CORDIC_STAGES-1][1]);
  end

  always_ff @(posedge clk) begin
    if (en[S_SQ]) begin
      sq1_r <= CW'(p_s1 >>> QBITS);
      sq2_r <= CW'(p_s2 >>> QBITS);
      cc_r  <= CW'(p_cc >>> QBITS);
    end
  end

  // a = sin^2(dphi/2) + cos*cos*sin^2(dlam/2)
  logic signed [CW:0]     a_r;
  logic signed [2*CW-1:0] p_t;

  assign p_t = (2*CW)'(cc_r) * (2*CW)'(sq2_r);

  always_ff @(posedge clk) begin
    if (en[S_AB]) begin
      a_r <= (CW+1)'(sq1_r) + (CW+1)'(p_t >>> QBITS);
    end
  end

  // clamp a and form the two radicands
  logic [63:0] ny0_r, nx0_r;
  logic [30:0] a_cl;

  always_comb begin
    if (a_r < 0) begin
      a_cl = '0;
    end else if (a_r > (CW+1)'(QONE)) begin
      a_cl = 31'(QONE);
    end else begin
      a_cl = a_r[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_CL]) begin
      ny0_r <= 64'(a_cl) << QBITS;
      nx0_r <= 64'(31'(QONE) - a_cl) << QBITS;
    end
  end

  // square roots, one result bit per stage
  logic [63:0] yn_r [SQRT_STAGES];
  logic [63:0] yq_r [SQRT_STAGES];
  logic [63:0] xn_r [SQRT_STAGES];
  logic [63:0] xq_r [SQRT_STAGES];

  generate
    for (i = 0; i < SQRT_STAGES; i++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'd1 << (62 - 2*i);
      logic [63:0] yn, yq, xn, xq, yt, xt;
      always_comb begin
        if (i == 0) begin
          yn = ny0_r;
          yq = '0;
          xn = nx0_r;
          xq = '0;
        end else begin
          yn = yn_r[(i == 0) ? 0 : i-1];
          yq = yq_r[(i == 0) ? 0 : i-1];
          xn = xn_r[(i == 0) ? 0 : i-1];
          xq = xq_r[(i == 0) ? 0 : i-1];
        end
        yt = yq + BIT;
        xt = xq + BIT;
      end
      always_ff @(posedge clk) begin
        if (en[S_RT+i]) begin
          if (yn >= yt) begin
            yn_r[i] <= yn - yt;
            yq_r[i] <= (yq >> 1) + BIT;
          end else begin
            yn_r[i] <= yn;
            yq_r[i] <= yq >> 1;
          end
          if (xn >= xt) begin
            xn_r[i] <= xn - xt;
            xq_r[i] <= (xq >> 1) + BIT;
          end else begin
            xn_r[i] <= xn;
            xq_r[i] <= xq >> 1;
          end
        end
      end
    end
  endgenerate

  // vectoring cordic for atan2
  logic signed [CW-1:0] vx_r [CORDIC_STAGES];
  logic signed [CW-1:0] vy_r [CORDIC_STAGES];
  logic signed [CW-1:0] vz_r [CORDIC_STAGES];

  generate
    for (i = 0; i < CORDIC_STAGES; i++) begin : g_vec
      logic signed [CW-1:0] xi, yi, zi;
      always_comb begin
        if (i == 0) begin
          xi = CW'(xq_r[SQRT_STAGES-1]);
          yi = CW'(yq_r[SQRT_STAGES-1]);
          zi = '0;
        end else begin
          xi = vx_r[(i == 0) ? 0 : i-1];
          yi = vy_r[(i == 0) ? 0 : i-1];
          zi = vz_r[(i == 0) ? 0 : i-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en[S_VEC+i]) begin
          if (yi >= 0) begin
            vx_r[i] <= xi + (yi >>> i);
            vy_r[i] <= yi - (xi >>> i);
            vz_r[i] <= zi + atan_tab(i);
          end else begin
            vx_r[i] <= xi - (yi >>> i);
            vy_r[i] <= yi + (xi >>> i);
            vz_r[i] <= zi - atan_tab(i);
          end
        end
      end
    end
  endgenerate

  // scale central angle by the diameter, round half up
  logic [32:0] zpos;
  logic [47:0] km_prod;
  logic [17:0] km_r;

  always_comb begin
    zpos    = (vz_r[CORDIC_STAGES-1] < 0) ? '0 : vz_r[CORDIC_STAGES-1][32:0];
    km_prod = 48'(zpos) * 48'(DIAM_KM) + (48'd1 << (QBITS - 1));
  end

  always_ff @(posedge clk) begin
    if (en[S_KM]) begin
      km_r <= 18'(km_prod >> QBITS);
    end
  end

  // saturate into the output register
  logic [14:0] dist_r;

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      dist_r <= (km_r > 18'(DIST_LIMIT)) ? DIST_LIMIT : km_r[14:0];
    end
  end

  assign out_dist_km = dist_r;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import gcd_pkg::*;

  // distance predictor and store of expected distances
  class distance_board;
    longint       atan_q30[CORDIC_STAGES];
    longint       pi_q30;
    longint       gain_inv;
    longint unsigned deg_rad_q60;
    logic [14:0]  expected_km[$];
    int           mismatches;
    int           unexpected;
    int           results_seen;
    int           requests_seen;

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n   = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function longint arccot_q60(longint unsigned n);
      longint unsigned p;
      longint unsigned n2;
      longint          sum;
      longint          term;
      longint unsigned k;
      p   = (64'd1 << 60) / n;
      n2  = n * n;
      sum = 0;
      k   = 0;
      while (p != 0) begin
        term = longint'(p / (2 * k + 1));
        sum  = k[0] ? sum - term : sum + term;
        p    = p / n2;
        k++;
      end
      return sum;
    endfunction

    function longint atan_step_q60(int i);
      longint sum;
      longint term;
      int     e;
      sum = 0;
      for (int k = 0; 60 - i * (2 * k + 1) >= 0; k++) begin
        e    = 60 - i * (2 * k + 1);
        term = (64'sd1 <<< e) / (2 * k + 1);
        sum  = (k % 2) ? sum - term : sum + term;
      end
      return sum;
    endfunction

    function new();
      longint          pi60;
      longint          v;
      longint unsigned g;
      pi60        = 16 * arccot_q60(5) - 4 * arccot_q60(239);
      pi_q30      = (pi60 + (64'sd1 <<< 29)) >>> 30;
      deg_rad_q60 = longint'(pi60) / 180;
      g = 64'd1 << 60;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        v = (i == 0) ? pi60 / 4 : atan_step_q60(i);
        atan_q30[i] = (v + (64'sd1 <<< 29)) >>> 30;
        g = g + (g >> (2 * i));
      end
      gain_inv = longint'((64'd1 << 60) / int_sqrt(g));
    endfunction

    function longint sat(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    // degrees (fixed point) to radians in Q30, truncated toward zero
    function longint radians(longint raw, int sh);
      logic [127:0]    prod;
      longint unsigned mag;
      longint          r;
      mag  = (raw < 0) ? -raw : raw;
      prod = {64'd0, mag} * {64'd0, deg_rad_q60};
      r    = longint'(prod >> sh);
      return (raw < 0) ? -r : r;
    endfunction

    // rotation mode: returns cosine and sine of theta
    function void rotate(longint theta, output longint cs, output longint sn);
      longint x, y, z, dx, dy;
      x = gain_inv;
      y = 0;
      z = theta;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - atan_q30[i];
        end else begin
          x = x + dx; y = y - dy; z = z + atan_q30[i];
        end
      end
      cs = x;
      sn = y;
    endfunction

    function logic [14:0] haversine_km(longint slat, longint slon, longint elat,
                                       longint elon);
      longint lat1, lon1, lat2, lon2, phi1, phi2, hdphi, hdlam;
      longint c1, c2, s1, s2, t, a, x, y, z, dx, dy, km;
      lat1  = sat(slat, 64'sd90 <<< ANGLE_FRAC_BITS);
      lon1  = sat(slon, 64'sd180 <<< ANGLE_FRAC_BITS);
      lat2  = sat(elat, 64'sd90 <<< ANGLE_FRAC_BITS);
      lon2  = sat(elon, 64'sd180 <<< ANGLE_FRAC_BITS);
      phi1  = radians(lat1, QBITS + ANGLE_FRAC_BITS);
      phi2  = radians(lat2, QBITS + ANGLE_FRAC_BITS);
      hdphi = radians(lat2 - lat1, QBITS + 1 + ANGLE_FRAC_BITS);
      hdlam = radians(lon2 - lon1, QBITS + 1 + ANGLE_FRAC_BITS);
      if (hdphi < 0) hdphi = -hdphi;
      if (hdlam < 0) hdlam = -hdlam;
      // fold half longitude difference past a right angle
      if (2 * hdlam > pi_q30) hdlam = pi_q30 - hdlam;
      if (phi1 < 0) phi1 = -phi1;
      if (phi2 < 0) phi2 = -phi2;
      rotate(phi1, c1, t);
      rotate(phi2, c2, t);
      rotate(hdphi, t, s1);
      rotate(hdlam, t, s2);
      s1 = (s1 * s1) >>> QBITS;
      s2 = (s2 * s2) >>> QBITS;
      t  = (c1 * c2) >>> QBITS;
      a  = s1 + ((t * s2) >>> QBITS);
      if (a < 0) a = 0;
      if (a > (64'sd1 <<< QBITS)) a = 64'sd1 <<< QBITS;
      y = longint'(int_sqrt(longint'(a) << QBITS));
      x = longint'(int_sqrt(longint'((64'sd1 <<< QBITS) - a) << QBITS));
      z = 0;
      // vectoring mode gives atan2(y, x)
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx; y = y - dy; z = z + atan_q30[i];
        end else begin
          x = x - dx; y = y + dy; z = z - atan_q30[i];
        end
      end
      if (z < 0) z = 0;
      km = (2 * 6371 * z + (64'sd1 <<< (QBITS - 1))) >>> QBITS;
      if (km > 20015) km = 20015;
      return km[14:0];
    endfunction

    function void note_request(longint slat, longint slon, longint elat, longint elon);
      expected_km.push_back(haversine_km(slat, slon, elat, elon));
      requests_seen++;
    endfunction

    function void check_result(logic [14:0] got);
      logic [14:0] want;
      results_seen++;
      if (expected_km.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("ERROR: distance %0d with no request pending", got);
        return;
      end
      want = expected_km.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches + unexpected <= 10)
          $display("ERROR: result %0d out_dist_km expected %0d got %0d",
                   results_seen, want, got);
      end
    endfunction

    function int pending();
      return expected_km.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [23:0] in_start_latitude;
  logic signed [24:0] in_start_longitude;
  logic signed [23:0] in_end_latitude;
  logic signed [24:0] in_end_longitude;
  logic               out_valid;
  logic               out_ready;
  logic [14:0]        out_dist_km;

  distance_board board;
  bit sender_idles;
  bit receiver_idles;
  bit hold_receiver;
  int hold_count;

  great_circle_distance u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_start_latitude  (in_start_latitude),
    .in_start_longitude (in_start_longitude),
    .in_end_latitude    (in_end_latitude),
    .in_end_longitude   (in_end_longitude),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_dist_km        (out_dist_km)
  );

  // clock
  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_dist_km);
  end

  // receiver stalls: random bursts, one long hold on request
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_receiver) begin
        out_ready <= 1'b0;
        hold_count = 0;
        while (hold_count < 400) begin
          @(posedge clk);
          hold_count++;
        end
        hold_receiver = 0;
      end else if (receiver_idles && $urandom_range(3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(10, 1);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(12, 1);
        repeat (n) @(posedge clk);
      end
    end
  end

  // one request; valid stays up across back-to-back requests
  task automatic send_request(longint slat, longint slon, longint elat, longint elon);
    int gap;
    gap = (sender_idles && $urandom_range(3) == 0) ? $urandom_range(10, 1) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_start_latitude  <= slat[23:0];
    in_start_longitude <= slon[24:0];
    in_end_latitude    <= elat[23:0];
    in_end_longitude   <= elon[24:0];
    do @(posedge clk); while (!in_ready);
    board.note_request(longint'(in_start_latitude), longint'(in_start_longitude),
                       longint'(in_end_latitude), longint'(in_end_longitude));
  endtask

  function automatic longint pick(longint lim);
    return longint'($urandom_range(2 * lim)) - lim;
  endfunction

  // random request: raw full-width noise, uniform, near antipodal or close points
  task automatic send_random();
    longint la1, lo1, la2, lo2;
    longint lat_lim, lon_lim;
    int kind;
    lat_lim = 64'sd90 <<< 16;
    lon_lim = 64'sd180 <<< 16;
    kind = $urandom_range(9);
    la1 = pick(lat_lim);
    lo1 = pick(lon_lim);
    case (kind)
      0: begin
        la1 = longint'($signed(24'($urandom)));
        lo1 = longint'($signed(25'($urandom)));
        la2 = longint'($signed(24'($urandom)));
        lo2 = longint'($signed(25'($urandom)));
      end
      1, 2: begin
        la2 = -la1 + pick(70000);
        lo2 = lo1 + ((lo1 < 0) ? lon_lim : -lon_lim) + pick(70000);
      end
      3, 4: begin
        la2 = la1 + pick($urandom_range(4) == 0 ? 30 : 300000);
        lo2 = lo1 + pick(300000);
      end
      default: begin
        la2 = pick(lat_lim);
        lo2 = pick(lon_lim);
      end
    endcase
    la2 = board.sat(la2, 64'sd8388607);
    lo2 = board.sat(lo2, 64'sd16777215);
    send_request(la1, lo1, la2, lo2);
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk);
  endtask

  // watchdog
  initial begin
    #4000000;
    $display("** great_circle_distance: FAILED **");
    $finish;
  end

  initial begin
    longint d90, d180;
    board              = new();
    d90                = 64'sd90 <<< 16;
    d180               = 64'sd180 <<< 16;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_start_latitude  = '0;
    in_start_longitude = '0;
    in_end_latitude    = '0;
    in_end_longitude   = '0;
    sender_idles       = 0;
    receiver_idles     = 0;
    hold_receiver      = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identical points, poles, antipodes, saturation, folding
    send_request(0, 0, 0, 0);
    send_request(d90, 0, -d90, 0);
    send_request(d90, d180, d90, -d180);
    send_request(0, 0, 0, d180);
    send_request(0, -d180, 0, d180);
    send_request(0, d180 / 2, 0, -d180 / 2);
    send_request(0, d180 - 100, 0, -d180 + 100);
    send_request(30 <<< 16, 10 <<< 16, -(30 <<< 16), -(170 <<< 16));
    send_request(8388607, 16777215, -8388608, -16777216);
    send_request(-8388608, -16777216, 8388607, 16777215);
    send_request(d90 + 1, d180 + 1, -d90 - 1, -d180 - 1);
    send_request(1, 1, 0, 0);
    send_request(-1, -1, 0, 0);
    send_request(12345, 67890, 12345, 67891);
    send_request(45 <<< 16, 0, 45 <<< 16, 90 <<< 16);
    send_request(-(60 <<< 16), 100 <<< 16, 60 <<< 16, -(80 <<< 16));
    send_request(d90, 0, d90 - 1, 123456);
    send_request(0, 0, 1, 0);
    send_request(d90, d180, -d90 + 1, 0);
    send_request(-d90, -d180, d90, d180);

    // random with idling on both sides
    sender_idles   = 1;
    receiver_idles = 1;
    repeat (600) send_random();

    // long receiver hold while requests keep coming
    hold_receiver = 1;
    repeat (500) send_random();

    // sender waits for everything to drain
    in_valid <= 1'b0;
    wait_drained();
    @(posedge clk);
    repeat (300) send_random();

    // final stretch with no idling
    sender_idles   = 0;
    receiver_idles = 0;
    repeat (300) send_random();
    in_valid <= 1'b0;

    wait_drained();
    repeat (NSTAGE + 20) @(posedge clk);
    $display("covered %0d requests (directed corners, saturation, folding, antipodes)",
             board.requests_seen);
    $display("checked %0d distances, including a long output hold and a full drain",
             board.results_seen);
    if (board.mismatches == 0 && board.unexpected == 0 && board.pending() == 0) begin
      $display("** great_circle_distance: PASSED **");
    end else begin
      $display("** great_circle_distance: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/gcd_pkg.sv
design/great_circle_distance.sv
tb/testbench.sv
